[design/tcf_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// tcf_pkg
// Shared types, codes and constants of the tilt complementary filter.
// ============================================================================
package tcf_pkg;

    // Item function codes
    localparam logic [1:0] FN_TICK   = 2'd0;
    localparam logic [1:0] FN_SAMPLE = 2'd1;
    localparam logic [1:0] FN_SET    = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_AX_OFF  = 3'd0;
    localparam logic [2:0] REG_AY_OFF  = 3'd1;
    localparam logic [2:0] REG_AZ_OFF  = 3'd2;
    localparam logic [2:0] REG_GZ_OFF  = 3'd3;
    localparam logic [2:0] REG_ACC_W   = 3'd4;
    localparam logic [2:0] REG_GYR_W   = 3'd5;
    localparam logic [2:0] REG_TICK_G  = 3'd6;
    localparam int         NUM_REGS    = 7;

    // Multiplier operand selects
    localparam logic [2:0] MS_AXAX  = 3'd0;
    localparam logic [2:0] MS_AZAZ  = 3'd1;
    localparam logic [2:0] MS_ACCW  = 3'd2;
    localparam logic [2:0] MS_FUSW  = 3'd3;
    localparam logic [2:0] MS_RATEG = 3'd4;

    localparam int TAB_IDX_W = 5;

    // Commands from controller to datapath
    typedef struct packed {
        logic                 capture;
        logic                 mul_en;
        logic [2:0]           mul_sel;
        logic                 sq_load;
        logic                 sq_add;
        logic                 sqrt_init;
        logic                 sqrt_step;
        logic                 cord_init;
        logic                 cord_step;
        logic [TAB_IDX_W-1:0] cord_idx;
        logic                 acc_fin;
        logic                 sum_load;
        logic                 blend_fin;
        logic                 tick_fin;
        logic                 set_fin;
        logic                 out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic sqrt_done;
        logic out_free;
    } t_sts;

    // atan(2^-i) in degree * 2^16
    function automatic logic [21:0] atan_deg(input logic [TAB_IDX_W-1:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

[design/tcf_in_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// tcf_in_if
// Input item channel: function code, raw IMU samples and angle to load.
// ============================================================================
interface tcf_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_z;
    logic signed [23:0] new_angle;

    modport source (output valid, func, accel_x, accel_y, accel_z, gyro_z, new_angle,
                    input ready);
    modport sink   (input valid, func, accel_x, accel_y, accel_z, gyro_z, new_angle,
                    output ready);
endinterface

[design/tcf_out_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// tcf_out_if
// Result channel: fused angle and accel-only angle.
// ============================================================================
interface tcf_out_if #(
    parameter int ANGLE_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] angle;
    logic signed [15:0]           accel_angle;

    modport source (output valid, angle, accel_angle, input ready);
    modport sink   (input valid, angle, accel_angle, output ready);
endinterface

[design/tcf_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// tcf_ctrl
// Sequencer: steps the datapath through multiply, square root, CORDIC and
// blend for a sample, and through the short tick and set sequences.
// ============================================================================
module tcf_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_func,
    output logic          o_in_ready,
    input  tcf_pkg::t_sts i_sts,
    output tcf_pkg::t_cmd o_cmd
);
    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(CORDIC_STEPS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQX   = 4'd1;
    localparam logic [3:0] S_SQZ   = 4'd2;
    localparam logic [3:0] S_SQADD = 4'd3;
    localparam logic [3:0] S_SINIT = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_CINIT = 4'd6;
    localparam logic [3:0] S_CSTEP = 4'd7;
    localparam logic [3:0] S_AFIN  = 4'd8;
    localparam logic [3:0] S_BMUL1 = 4'd9;
    localparam logic [3:0] S_BMUL2 = 4'd10;
    localparam logic [3:0] S_BFIN  = 4'd11;
    localparam logic [3:0] S_TMUL  = 4'd12;
    localparam logic [3:0] S_TFIN  = 4'd13;
    localparam logic [3:0] S_SET   = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    function automatic logic [tcf_pkg::TAB_IDX_W-1:0] TAB_IDX_CAST(input logic [CW-1:0] c);
        return tcf_pkg::TAB_IDX_W'(c);
    endfunction

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.cord_idx = TAB_IDX_CAST(r_cnt);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_func)
                        tcf_pkg::FN_TICK:   n_state = S_TMUL;
                        tcf_pkg::FN_SAMPLE: n_state = S_SQX;
                        tcf_pkg::FN_SET:    n_state = S_SET;
                        default:            n_state = S_OUT;
                    endcase
                end
            end
            S_SQX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tcf_pkg::MS_AXAX;
                n_state = S_SQZ;
            end
            S_SQZ: begin
                o_cmd.sq_load = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tcf_pkg::MS_AZAZ;
                n_state = S_SQADD;
            end
            S_SQADD: begin
                o_cmd.sq_add = 1'b1;
                n_state = S_SINIT;
            end
            S_SINIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (i_sts.sqrt_done) begin
                    n_state = S_CINIT;
                end else begin
                    o_cmd.sqrt_step = 1'b1;
                end
            end
            S_CINIT: begin
                o_cmd.cord_init = 1'b1;
                n_cnt   = '0;
                n_state = S_CSTEP;
            end
            S_CSTEP: begin
                o_cmd.cord_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_AFIN;
                end
            end
            S_AFIN: begin
                o_cmd.acc_fin = 1'b1;
                n_state = S_BMUL1;
            end
            S_BMUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tcf_pkg::MS_ACCW;
                n_state = S_BMUL2;
            end
            S_BMUL2: begin
                o_cmd.sum_load = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = tcf_pkg::MS_FUSW;
                n_state = S_BFIN;
            end
            S_BFIN: begin
                o_cmd.blend_fin = 1'b1;
                n_state = S_OUT;
            end
            S_TMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tcf_pkg::MS_RATEG;
                n_state = S_TFIN;
            end
            S_TFIN: begin
                o_cmd.tick_fin = 1'b1;
                n_state = S_OUT;
            end
            S_SET: begin
                o_cmd.set_fin = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

[design/tcf_dp.sv]
`timescale 1ns / 1ps
// ============================================================================
// tcf_dp
// Datapath: config registers, offset correction, shared multiplier,
// bit-pair square root, vectoring CORDIC, blend/tick/set and result register.
// ============================================================================
module tcf_dp #(
    parameter int ANGLE_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_idx,
    input  logic [15:0]                  i_cfg_data,
    input  logic [1:0]                   i_func,
    input  logic signed [15:0]           i_accel_x,
    input  logic signed [15:0]           i_accel_y,
    input  logic signed [15:0]           i_accel_z,
    input  logic signed [15:0]           i_gyro_z,
    input  logic signed [23:0]           i_new_angle,
    input  tcf_pkg::t_cmd                i_cmd,
    output tcf_pkg::t_sts                o_sts,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic signed [ANGLE_BITS-1:0] o_angle,
    output logic signed [15:0]           o_accel_angle
);
    localparam int PW = ANGLE_BITS + 17;
    localparam logic signed [63:0] A_MAX = (64'sd1 <<< (ANGLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] A_MIN = -A_MAX - 64'sd1;
    localparam logic signed [25:0] ACC_LIM = 26'sd23040;

    function automatic logic signed [ANGLE_BITS-1:0] f_sat(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = (v > A_MAX) ? A_MAX : ((v < A_MIN) ? A_MIN : v);
        return ANGLE_BITS'(c);
    endfunction

    logic [15:0]                  r_cfg [tcf_pkg::NUM_REGS];
    logic signed [16:0]           r_ax, r_ay, r_az, r_rate;
    logic signed [23:0]           r_nang;
    logic signed [PW-1:0]         r_prod;
    logic signed [PW:0]           r_sum;
    logic [33:0]                  r_sq;
    logic [34:0]                  r_rem, r_root, r_bit;
    logic signed [36:0]           r_cx, r_cy;
    logic signed [25:0]           r_cz;
    logic signed [ANGLE_BITS-1:0] r_fused;
    logic signed [15:0]           r_acc;
    logic                         r_out_valid;
    logic signed [ANGLE_BITS-1:0] r_out_angle;
    logic signed [15:0]           r_out_acc;

    // Config registers; index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[tcf_pkg::REG_AX_OFF] <= 16'd0;
            r_cfg[tcf_pkg::REG_AY_OFF] <= 16'd0;
            r_cfg[tcf_pkg::REG_AZ_OFF] <= 16'd0;
            r_cfg[tcf_pkg::REG_GZ_OFF] <= 16'd0;
            r_cfg[tcf_pkg::REG_ACC_W]  <= 16'd655;
            r_cfg[tcf_pkg::REG_GYR_W]  <= 16'd32113;
            r_cfg[tcf_pkg::REG_TICK_G] <= 16'd1280;
        end else if (i_cfg_we && (i_cfg_idx < 3'(tcf_pkg::NUM_REGS))) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Shared multiplier operand select
    logic signed [ANGLE_BITS-1:0] w_ma;
    logic signed [16:0]           w_mb;
    logic signed [PW-1:0]         w_prod;
    always_comb begin
        case (i_cmd.mul_sel)
            tcf_pkg::MS_AXAX: begin
                w_ma = ANGLE_BITS'(r_ax);
                w_mb = r_ax;
            end
            tcf_pkg::MS_AZAZ: begin
                w_ma = ANGLE_BITS'(r_az);
                w_mb = r_az;
            end
            tcf_pkg::MS_ACCW: begin
                w_ma = ANGLE_BITS'(r_acc);
                w_mb = signed'({1'b0, r_cfg[tcf_pkg::REG_ACC_W]});
            end
            tcf_pkg::MS_FUSW: begin
                w_ma = r_fused;
                w_mb = signed'({1'b0, r_cfg[tcf_pkg::REG_GYR_W]});
            end
            default: begin
                w_ma = ANGLE_BITS'(r_rate);
                w_mb = signed'({1'b0, r_cfg[tcf_pkg::REG_TICK_G]});
            end
        endcase
    end
    assign w_prod = PW'(w_ma) * PW'(w_mb);

    // Square root step: one result bit per cycle
    logic [34:0] w_trial;
    assign w_trial = r_root + r_bit;

    // CORDIC step
    logic signed [36:0] w_xs, w_ys;
    logic signed [25:0] w_at;
    assign w_xs = r_cx >>> i_cmd.cord_idx;
    assign w_ys = r_cy >>> i_cmd.cord_idx;
    assign w_at = signed'(26'(tcf_pkg::atan_deg(i_cmd.cord_idx)));

    // Accel angle rounding and clamp
    logic signed [25:0] w_rz, w_cl;
    logic               w_zero;
    assign w_rz   = (r_cz + 26'sd128) >>> 8;
    assign w_cl   = (w_rz > ACC_LIM) ? ACC_LIM : ((w_rz < -ACC_LIM) ? -ACC_LIM : w_rz);
    assign w_zero = (r_ax == 17'sd0) && (r_ay == 17'sd0) && (r_az == 17'sd0);

    // Final angle updates
    logic signed [63:0] w_blend, w_tick;
    assign w_blend = (64'(r_sum) + 64'(r_prod) + 64'sd16384) >>> 15;
    assign w_tick  = 64'(r_fused) + ((64'(r_prod) + 64'sd32768) >>> 16);

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ax   <= 17'(i_accel_x) + 17'(signed'(r_cfg[tcf_pkg::REG_AX_OFF]));
            r_ay   <= 17'(i_accel_y) + 17'(signed'(r_cfg[tcf_pkg::REG_AY_OFF]));
            r_az   <= 17'(i_accel_z) + 17'(signed'(r_cfg[tcf_pkg::REG_AZ_OFF]));
            r_nang <= i_new_angle;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.sq_load) begin
            r_sq <= 34'(r_prod);
        end else if (i_cmd.sq_add) begin
            r_sq <= r_sq + 34'(r_prod);
        end
        if (i_cmd.sqrt_init) begin
            r_rem  <= 35'(r_sq);
            r_root <= '0;
            r_bit  <= 35'd1 << 32;
        end else if (i_cmd.sqrt_step) begin
            if (r_rem >= w_trial) begin
                r_rem  <= r_rem - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.cord_init) begin
            r_cx <= signed'(37'({r_root[17:0], 14'b0}));
            r_cy <= 37'(r_ay) <<< 14;
            r_cz <= '0;
        end else if (i_cmd.cord_step) begin
            if (r_cy < 0) begin
                r_cx <= r_cx - w_ys;
                r_cy <= r_cy + w_xs;
                r_cz <= r_cz - w_at;
            end else begin
                r_cx <= r_cx + w_ys;
                r_cy <= r_cy - w_xs;
                r_cz <= r_cz + w_at;
            end
        end
        if (i_cmd.sum_load) begin
            r_sum <= (PW + 1)'(r_prod);
        end
    end

    // Filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fused <= '0;
            r_rate  <= '0;
            r_acc   <= '0;
        end else begin
            if (i_cmd.capture && (i_func == tcf_pkg::FN_SAMPLE)) begin
                r_rate <= 17'(i_gyro_z) + 17'(signed'(r_cfg[tcf_pkg::REG_GZ_OFF]));
            end
            if (i_cmd.acc_fin) begin
                r_acc <= w_zero ? 16'sd0 : 16'(w_cl);
            end
            if (i_cmd.blend_fin) begin
                r_fused <= f_sat(w_blend);
            end else if (i_cmd.tick_fin) begin
                r_fused <= f_sat(w_tick);
            end else if (i_cmd.set_fin) begin
                r_fused <= f_sat(64'(r_nang));
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_angle <= r_fused;
            r_out_acc   <= r_acc;
        end
    end

    assign o_sts.sqrt_done = (r_bit == '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_angle         = r_out_angle;
    assign o_accel_angle   = r_out_acc;

endmodule

[design/tilt_complementary_filter.sv]
`timescale 1ns / 1ps
// ============================================================================
// tilt_complementary_filter
// Fuses raw accel/gyro samples into a saturating tilt angle in 1/256 degree.
// ============================================================================
// One item is processed at a time and gives one result. A sample goes
// through 17 square-root iterations on |(ax, az)|, the CORDIC_STEPS
// iterations of the vectoring CORDIC, and passes through the single shared
// multiplier for the squares and the blend. A tick passes once through the
// multiplier, a set loads the new angle, and an unused function code gives
// a result with no update. The input is ready again in the cycle after the
// result is loaded into the output register; a result still waiting in that
// register does not block the next transaction from being accepted.
module tilt_complementary_filter #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS   = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    tcf_in_if.sink      i_in,
    tcf_out_if.source   o_out
);
    tcf_pkg::t_cmd w_cmd;
    tcf_pkg::t_sts w_sts;
    logic          w_in_ready;

    assign i_in.ready = w_in_ready;

    // Sequencer
    tcf_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_func     (i_in.func),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath
    tcf_dp #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_in.func),
        .i_accel_x     (i_in.accel_x),
        .i_accel_y     (i_in.accel_y),
        .i_accel_z     (i_in.accel_z),
        .i_gyro_z      (i_in.gyro_z),
        .i_new_angle   (i_in.new_angle),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_angle       (o_out.angle),
        .o_accel_angle (o_out.accel_angle)
    );

    // A result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result loaded while output register occupied");

    // Only one transaction in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && w_in_ready) |=> !w_in_ready)
        else $error("input ready right after a transaction");

    // Output valid only rises from a result load
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.out_load))
        else $error("output valid rose without a result load");

    // Square root and CORDIC never run together, and no item is captured during a CORDIC step
    a_step_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.cord_step |-> !w_cmd.sqrt_step && !w_cmd.capture)
        else $error("overlapping iteration commands");

endmodule
